>>> rtl/lclr_pkg.sv
`default_nettype none
package lclr_pkg;

    localparam int MAX_ATOMS = 1024;
    localparam int MAX_CELLS = 4096;
    localparam int ATOM_W    = $clog2(MAX_ATOMS);
    localparam int CELL_W    = $clog2(MAX_CELLS);
    localparam int DIV_W     = 36;
    localparam int DIV_CW    = $clog2(DIV_W + 1);

    localparam logic [1:0] CMD_UPD  = 2'd0;
    localparam logic [1:0] CMD_HEAD = 2'd1;
    localparam logic [1:0] CMD_NEXT = 2'd2;

    localparam logic [1:0] PH_CMOD = 2'd0;
    localparam logic [1:0] PH_CIDX = 2'd1;
    localparam logic [1:0] PH_DMOD = 2'd2;

    localparam logic [2:0] REG_NUM_ATOMS = 3'd0;
    localparam logic [2:0] REG_BOX_X     = 3'd1;
    localparam logic [2:0] REG_BOX_Y     = 3'd2;
    localparam logic [2:0] REG_BOX_Z     = 3'd3;
    localparam logic [2:0] REG_CELLS_X   = 3'd4;
    localparam logic [2:0] REG_CELLS_Y   = 3'd5;
    localparam logic [2:0] REG_CELLS_Z   = 3'd6;
    localparam logic [2:0] REG_SKIN      = 3'd7;

    typedef struct packed {
        logic [10:0]      num_atoms;
        logic [2:0][30:0] box;
        logic [2:0][4:0]  cells;
        logic [30:0]      skin;
    } t_cfg;

    typedef struct packed {
        logic       ld_in;
        logic       clr_we;
        logic       div_start;
        logic       div_cap;
        logic [1:0] phase;
        logic [1:0] axis;
        logic       sq;
        logic       add;
        logic       sqrt_start;
        logic       ufin;
        logic       dec;
        logic       rd_cap;
        logic       cur_ld;
        logic       head_rd_cell;
        logic       bin_wr;
        logic       out_ld;
    } t_ctl;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic clr_last;
        logic atom_last;
        logic first;
        logic rebuild_go;
        logic out_free;
    } t_stat;

    function automatic logic [30:0] box_len(input logic [30:0] b);
        return (b == 31'd0) ? 31'd1 : b;
    endfunction

    function automatic logic [4:0] cell_cnt(input logic [4:0] c);
        if (c == 5'd0) begin
            return 5'd1;
        end
        return (c > 5'd16) ? 5'd16 : c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/lclr_div.sv
`default_nettype none
module lclr_div import lclr_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_W-1:0]  i_dvd,
    input  wire logic [30:0]       i_dvs,
    output logic      [30:0]       o_rem,
    output logic      [DIV_W-1:0]  o_quo,
    output logic                   o_done
);

    logic [30:0]      r_rem;
    logic [DIV_W-1:0] r_dvd;
    logic [DIV_CW-1:0] r_cnt;
    logic             r_done;
    logic [31:0]      t;
    logic             ge;

    assign t  = {r_rem, r_dvd[DIV_W-1]};
    assign ge = t >= {1'b0, i_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= DIV_CW'(DIV_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == DIV_CW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dvd;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? 31'(t - {1'b0, i_dvs}) : t[30:0];
            r_dvd <= {r_dvd[DIV_W-2:0], ge};
        end
    end

    assign o_rem  = r_rem;
    assign o_quo  = r_dvd;
    assign o_done = r_done;

endmodule
`default_nettype wire

>>> rtl/lclr_sqrt.sv
`default_nettype none
module lclr_sqrt import lclr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [61:0] i_val,
    output logic      [31:0] o_root,
    output logic             o_done
);

    logic [61:0] r_v;
    logic [62:0] r_res;
    logic [62:0] r_bit;
    logic        r_busy;
    logic        r_done;
    logic [62:0] t;

    assign t = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_busy <= !r_bit[0];
            r_done <= r_bit[0];
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_res <= '0;
            r_bit <= {1'b1, 62'd0};
        end else if (r_busy) begin
            if ({1'b0, r_v} >= t) begin
                r_v   <= 62'({1'b0, r_v} - t);
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root = r_res[31:0];
    assign o_done = r_done;

endmodule
`default_nettype wire

>>> rtl/lclr_dp.sv
`default_nettype none
module lclr_dp import lclr_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire t_ctl               i_ctl,
    output t_stat                   o_stat,
    input  wire logic [1:0]         i_cmd,
    input  wire logic [ATOM_W-1:0]  i_atom,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic               i_last,
    input  wire logic [CELL_W-1:0]  i_cell_sel,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic                    o_rebuilt,
    output logic                    o_count_error,
    output logic                    o_link_empty,
    output logic [ATOM_W-1:0]       o_link_atom,
    output logic [CELL_W-1:0]       o_atom_cell,
    output logic [31:0]             o_disp_sum
);

    logic [95:0]     cur_mem   [MAX_ATOMS];
    logic [95:0]     built_mem [MAX_ATOMS];
    logic [ATOM_W:0] head_mem  [MAX_CELLS];
    logic [ATOM_W:0] next_mem  [MAX_ATOMS];

    logic [2:0][31:0] cur_rd, built_rd;
    logic [ATOM_W:0]  head_rd, next_rd;

    logic [1:0]        r_op;
    logic [ATOM_W-1:0] r_atom;
    logic [2:0][31:0]  r_p;
    logic              r_last;
    logic [CELL_W-1:0] r_sel;
    logic [61:0]       r_sum;
    logic [30:0]       r_q;
    logic [2:0][3:0]   r_idx;
    logic [29:0]       r_a;
    logic [59:0]       r_sq;
    logic [31:0]       r_max1, r_max2;
    logic [10:0]       r_fcnt;
    logic              r_first;
    logic [ATOM_W:0]   r_i;
    logic [CELL_W-1:0] r_clr;
    logic              r_ov;
    logic              r_res_reb, r_res_err, r_res_emp;
    logic [ATOM_W-1:0] r_res_link;
    logic [CELL_W-1:0] r_res_cell;
    logic [31:0]       r_res_dsum;

    logic [30:0]       m;
    logic [4:0]        cnt, cx, cy;
    logic [31:0]       p_ax, b_ax, p_mag;
    logic [32:0]       d, d_mag;
    logic [DIV_W-1:0]  dvd;
    logic [30:0]       rem, fold, a_val;
    logic [DIV_W-1:0]  quo;
    logic              neg, div_done, sqrt_done;
    logic [31:0]       root, d_new;
    logic [9:0]        cxy;
    logic [13:0]       lin;
    logic [CELL_W-1:0] cell_lin;
    logic [32:0]       dsum;
    logic [ATOM_W:0]   n_lim;
    logic              count_bad, trig;
    logic [CELL_W-1:0] head_ra;
    logic [ATOM_W:0]   entry;

    assign m     = box_len(i_cfg.box[i_ctl.axis]);
    assign cnt   = cell_cnt(i_cfg.cells[i_ctl.axis]);
    assign p_ax  = r_p[i_ctl.axis];
    assign b_ax  = built_rd[i_ctl.axis];
    assign p_mag = p_ax[31] ? 32'(32'd0 - p_ax) : p_ax;
    assign d     = {p_ax[31], p_ax} - {b_ax[31], b_ax};
    assign d_mag = d[32] ? 33'(33'd0 - d) : d;

    always_comb begin
        case (i_ctl.phase)
            PH_CMOD: dvd = DIV_W'(p_mag);
            PH_CIDX: dvd = DIV_W'({5'd0, r_q} * {31'd0, cnt});
            PH_DMOD: dvd = DIV_W'(d_mag);
            default: dvd = '0;
        endcase
    end

    lclr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_dvd   (dvd),
        .i_dvs   (m),
        .o_rem   (rem),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    lclr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.sqrt_start),
        .i_val   (r_sum),
        .o_root  (root),
        .o_done  (sqrt_done)
    );

    assign neg   = (i_ctl.phase == PH_CMOD) ? p_ax[31] : d[32];
    assign fold  = (neg && rem != 31'd0) ? 31'(m - rem) : rem;
    assign a_val = ({fold, 1'b0} > {1'b0, m}) ? 31'(m - fold) : fold;

    assign cx       = cell_cnt(i_cfg.cells[0]);
    assign cy       = cell_cnt(i_cfg.cells[1]);
    assign cxy      = 10'(cx) * 10'(cy);
    assign lin      = 14'(r_idx[0]) + 14'(r_idx[1]) * 14'(cx) + 14'(r_idx[2]) * 14'(cxy);
    assign cell_lin = lin[CELL_W-1:0];

    assign d_new     = r_first ? 32'd0 : root;
    assign dsum      = {1'b0, r_max1} + {1'b0, r_max2};
    assign count_bad = r_fcnt != i_cfg.num_atoms;
    assign trig      = r_first || (dsum > {2'b0, i_cfg.skin});
    assign n_lim     = (i_cfg.num_atoms > 11'(MAX_ATOMS)) ? (ATOM_W+1)'(MAX_ATOMS)
                                                          : (ATOM_W+1)'(i_cfg.num_atoms);

    assign head_ra = i_ctl.head_rd_cell ? cell_lin : r_sel;
    assign entry   = (r_op == CMD_HEAD) ? head_rd : next_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_in && i_cmd == CMD_UPD) begin
            cur_mem[i_atom] <= {i_pos_z, i_pos_y, i_pos_x};
        end
        cur_rd <= cur_mem[r_i[ATOM_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.bin_wr) begin
            built_mem[r_i[ATOM_W-1:0]] <= r_p;
        end
        built_rd <= built_mem[r_atom];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_we) begin
            head_mem[r_clr] <= '0;
        end else if (i_ctl.bin_wr) begin
            head_mem[cell_lin] <= {1'b1, r_i[ATOM_W-1:0]};
        end
        head_rd <= head_mem[head_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_we && r_clr < CELL_W'(MAX_ATOMS)) begin
            next_mem[r_clr[ATOM_W-1:0]] <= '0;
        end else if (i_ctl.bin_wr) begin
            next_mem[r_i[ATOM_W-1:0]] <= head_rd;
        end
        next_rd <= next_mem[r_atom];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_first <= 1'b1;
            r_max1  <= '0;
            r_max2  <= '0;
            r_fcnt  <= '0;
            r_i     <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_ctl.clr_we) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_ctl.ufin) begin
                if (d_new > r_max1) begin
                    r_max2 <= r_max1;
                    r_max1 <= d_new;
                end else if (d_new > r_max2) begin
                    r_max2 <= d_new;
                end
                if (r_fcnt != 11'd2047) begin
                    r_fcnt <= r_fcnt + 1'b1;
                end
            end
            if (i_ctl.dec && r_last) begin
                r_max1 <= '0;
                r_max2 <= '0;
                r_fcnt <= '0;
                if (!count_bad && trig) begin
                    r_first <= 1'b0;
                    r_i     <= '0;
                end
            end
            if (i_ctl.bin_wr) begin
                r_i <= r_i + 1'b1;
            end
            if (i_ctl.out_ld) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_in) begin
            r_op       <= i_cmd;
            r_atom     <= i_atom;
            r_p        <= {i_pos_z, i_pos_y, i_pos_x};
            r_last     <= i_last;
            r_sel      <= i_cell_sel;
            r_sum      <= '0;
            r_res_reb  <= 1'b0;
            r_res_err  <= 1'b0;
            r_res_emp  <= 1'b0;
            r_res_link <= '0;
            r_res_cell <= '0;
            r_res_dsum <= '0;
        end
        if (i_ctl.cur_ld) begin
            r_p <= cur_rd;
        end
        if (i_ctl.div_cap) begin
            case (i_ctl.phase)
                PH_CMOD: r_q <= fold;
                PH_CIDX: r_idx[i_ctl.axis] <= quo[3:0];
                PH_DMOD: r_a <= a_val[29:0];
                default: r_q <= r_q;
            endcase
        end
        if (i_ctl.sq) begin
            r_sq <= r_a * r_a;
        end
        if (i_ctl.add) begin
            r_sum <= r_sum + 62'(r_sq);
        end
        if (i_ctl.dec) begin
            r_res_dsum <= dsum[31:0];
            r_res_cell <= cell_lin;
            if (r_last) begin
                r_res_err <= count_bad;
                r_res_reb <= !count_bad && trig;
            end
        end
        if (i_ctl.rd_cap) begin
            r_res_emp  <= !entry[ATOM_W];
            r_res_link <= entry[ATOM_W] ? entry[ATOM_W-1:0] : '0;
        end
        if (i_ctl.out_ld) begin
            o_rebuilt     <= r_res_reb;
            o_count_error <= r_res_err;
            o_link_empty  <= r_res_emp;
            o_link_atom   <= r_res_link;
            o_atom_cell   <= r_res_cell;
            o_disp_sum    <= r_res_dsum;
        end
    end

    assign o_out_valid = r_ov;

    always_comb begin
        o_stat.div_done   = div_done;
        o_stat.sqrt_done  = sqrt_done;
        o_stat.clr_last   = r_clr == CELL_W'(MAX_CELLS - 1);
        o_stat.atom_last  = (r_i + 1'b1) == n_lim;
        o_stat.first      = r_first;
        o_stat.rebuild_go = r_last && !count_bad && trig;
        o_stat.out_free   = !r_ov || i_out_ready;
    end

endmodule
`default_nettype wire

>>> rtl/lclr_ctrl.sv
`default_nettype none
module lclr_ctrl import lclr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_cmd,
    output logic            o_ready,
    input  wire t_stat      i_stat,
    output t_ctl            o_ctl
);

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DGO   = 5'd2;
    localparam logic [4:0] S_DWT   = 5'd3;
    localparam logic [4:0] S_SQ    = 5'd4;
    localparam logic [4:0] S_ADD   = 5'd5;
    localparam logic [4:0] S_SGO   = 5'd6;
    localparam logic [4:0] S_SWT   = 5'd7;
    localparam logic [4:0] S_UFIN  = 5'd8;
    localparam logic [4:0] S_DEC   = 5'd9;
    localparam logic [4:0] S_RD    = 5'd10;
    localparam logic [4:0] S_RDC   = 5'd11;
    localparam logic [4:0] S_BRD   = 5'd12;
    localparam logic [4:0] S_BLD   = 5'd13;
    localparam logic [4:0] S_BHEAD = 5'd14;
    localparam logic [4:0] S_BWR   = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;

    logic [4:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic [1:0] r_axis, n_axis;
    logic       r_bld, n_bld;
    logic [4:0] ax_state;
    logic [1:0] ax_next;

    always_comb begin
        ax_next = r_axis;
        if (r_axis == 2'd2) begin
            if (r_bld) begin
                ax_state = S_BHEAD;
            end else if (i_stat.first) begin
                ax_state = S_UFIN;
            end else begin
                ax_state = S_SGO;
            end
        end else begin
            ax_state = S_DGO;
            ax_next  = r_axis + 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_axis  = r_axis;
        n_bld   = r_bld;
        o_ctl   = '0;
        o_ctl.phase = r_phase;
        o_ctl.axis  = r_axis;
        o_ready = 1'b0;
        case (r_state)
            S_CLR: begin
                o_ctl.clr_we = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = r_bld ? S_BRD : S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctl.ld_in = 1'b1;
                    n_bld = 1'b0;
                    case (i_cmd)
                        CMD_UPD: begin
                            n_state = S_DGO;
                            n_phase = PH_CMOD;
                            n_axis  = 2'd0;
                        end
                        CMD_HEAD, CMD_NEXT: n_state = S_RD;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_DGO: begin
                o_ctl.div_start = 1'b1;
                n_state = S_DWT;
            end
            S_DWT: begin
                if (i_stat.div_done) begin
                    o_ctl.div_cap = 1'b1;
                    case (r_phase)
                        PH_CMOD: begin
                            n_phase = PH_CIDX;
                            n_state = S_DGO;
                        end
                        PH_CIDX: begin
                            if (!r_bld && !i_stat.first) begin
                                n_phase = PH_DMOD;
                                n_state = S_DGO;
                            end else begin
                                n_phase = PH_CMOD;
                                n_axis  = ax_next;
                                n_state = ax_state;
                            end
                        end
                        default: n_state = S_SQ;
                    endcase
                end
            end
            S_SQ: begin
                o_ctl.sq = 1'b1;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_ctl.add = 1'b1;
                n_phase = PH_CMOD;
                n_axis  = ax_next;
                n_state = ax_state;
            end
            S_SGO: begin
                o_ctl.sqrt_start = 1'b1;
                n_state = S_SWT;
            end
            S_SWT: begin
                if (i_stat.sqrt_done) begin
                    n_state = S_UFIN;
                end
            end
            S_UFIN: begin
                o_ctl.ufin = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                o_ctl.dec = 1'b1;
                if (i_stat.rebuild_go) begin
                    n_bld   = 1'b1;
                    n_state = S_CLR;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RD: n_state = S_RDC;
            S_RDC: begin
                o_ctl.rd_cap = 1'b1;
                n_state = S_OUT;
            end
            S_BRD: n_state = S_BLD;
            S_BLD: begin
                o_ctl.cur_ld = 1'b1;
                n_phase = PH_CMOD;
                n_axis  = 2'd0;
                n_state = S_DGO;
            end
            S_BHEAD: begin
                o_ctl.head_rd_cell = 1'b1;
                n_state = S_BWR;
            end
            S_BWR: begin
                o_ctl.bin_wr = 1'b1;
                n_state = i_stat.atom_last ? S_OUT : S_BRD;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_ctl.out_ld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_phase <= PH_CMOD;
            r_axis  <= 2'd0;
            r_bld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_axis  <= n_axis;
            r_bld   <= n_bld;
        end
    end

endmodule
`default_nettype wire

>>> rtl/linked_cell_list_rebuild.sv
// Linked cell list with a skin-triggered rebuild.
// Input channel i_valid/o_ready carries one command word: a position update
// (cmd 0), a cell head read (cmd 1) or an atom next-link read (cmd 2).
// Output channel o_valid/i_ready returns exactly one result word per command.
// Configuration sits on the APB port, one 32-bit register per 4 bytes;
// write it only while the block is idle.
// A head or next read passes through S_RD and S_RDC before S_OUT. In an update,
// each axis runs three 36-step passes through the shared restoring divider
// (wrap, cell index, minimum image), then a 32-step square root follows.
// In the first frame the minimum-image pass and the root are skipped.
// A frame end that rebuilds adds a clearing pass over the head and next-link
// memories plus a wrap and cell-index pass per atom through the same divider.
// One command is worked on at a time; the next is taken once the previous
// result sits in the output register, even while the receiver stalls.
// A stalled receiver holds the result and then holds back further input.
// After reset the block runs the clearing pass with o_ready low.
`default_nettype none
module linked_cell_list_rebuild import lclr_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_cmd,
    input  wire logic [ATOM_W-1:0]  i_atom,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic               i_last,
    input  wire logic [CELL_W-1:0]  i_cell_sel,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_rebuilt,
    output logic                    o_count_error,
    output logic                    o_link_empty,
    output logic [ATOM_W-1:0]       o_link_atom,
    output logic [CELL_W-1:0]       o_atom_cell,
    output logic [31:0]             o_disp_sum,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    t_cfg  r_cfg;
    t_ctl  ctl;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_atoms <= 11'd1024;
            r_cfg.box       <= {3{31'd65536000}};
            r_cfg.cells     <= {3{5'd3}};
            r_cfg.skin      <= 31'd65536;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_NUM_ATOMS: r_cfg.num_atoms <= pwdata[10:0];
                REG_BOX_X:     r_cfg.box[0]    <= pwdata[30:0];
                REG_BOX_Y:     r_cfg.box[1]    <= pwdata[30:0];
                REG_BOX_Z:     r_cfg.box[2]    <= pwdata[30:0];
                REG_CELLS_X:   r_cfg.cells[0]  <= pwdata[4:0];
                REG_CELLS_Y:   r_cfg.cells[1]  <= pwdata[4:0];
                REG_CELLS_Z:   r_cfg.cells[2]  <= pwdata[4:0];
                REG_SKIN:      r_cfg.skin      <= pwdata[30:0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_NUM_ATOMS: prdata = 32'(r_cfg.num_atoms);
            REG_BOX_X:     prdata = 32'(r_cfg.box[0]);
            REG_BOX_Y:     prdata = 32'(r_cfg.box[1]);
            REG_BOX_Z:     prdata = 32'(r_cfg.box[2]);
            REG_CELLS_X:   prdata = 32'(r_cfg.cells[0]);
            REG_CELLS_Y:   prdata = 32'(r_cfg.cells[1]);
            REG_CELLS_Z:   prdata = 32'(r_cfg.cells[2]);
            REG_SKIN:      prdata = 32'(r_cfg.skin);
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    lclr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    lclr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_ctl         (ctl),
        .o_stat        (stat),
        .i_cmd         (i_cmd),
        .i_atom        (i_atom),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_last        (i_last),
        .i_cell_sel    (i_cell_sel),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_rebuilt     (o_rebuilt),
        .o_count_error (o_count_error),
        .o_link_empty  (o_link_empty),
        .o_link_atom   (o_link_atom),
        .o_atom_cell   (o_atom_cell),
        .o_disp_sum    (o_disp_sum)
    );

endmodule
`default_nettype wire
